[design/particle_code_converter_assert.svh]
// Assertion macros used by the particle code converter top level.
`ifndef PARTICLE_CODE_CONVERTER_ASSERT_SVH
`define PARTICLE_CODE_CONVERTER_ASSERT_SVH

// Clocked check, off while reset is held.
`define PCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PCC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/pcc_pkg.sv]
// Types, constants and lookup tables of the particle code converter.
package pcc_pkg;

    typedef logic signed [31:0] t_code;

    typedef enum logic [1:0] {
        CMD_OLD_TO_STD = 2'd0,
        CMD_NEW_TO_STD = 2'd1,
        CMD_STD_TO_OLD = 2'd2,
        CMD_STD_TO_NEW = 2'd3
    } t_cmd;

    typedef struct packed {
        logic  hit;
        t_code val;
    } t_dir;

    typedef struct packed {
        logic        neg;
        logic        ion_rng;
        logic [21:0] q1;
        logic [11:0] q2;
        logic [9:0]  low3;
        logic [20:0] q10;
        logic [11:0] z;
        logic [3:0]  iso;
    } t_digits;

    localparam int OLD_COUNT    = 35;
    localparam int NEW_COUNT    = 37;
    localparam logic [5:0] NEW_ION_TYPE = 6'd37;

    localparam logic [31:0] ION_BASE = 32'd1000000000;
    localparam logic [31:0] ION_MAX  = 32'd1009999990;

    // Reciprocals for exact division by constants: q = (x * K) >> shift.
    localparam logic [31:0] K_DIV1000_A = 32'd2199023256; // shift 41, x < 2^31
    localparam logic [22:0] K_DIV1000_B = 23'd4294968;    // shift 32, x < 2^22
    localparam logic [23:0] K_DIV10     = 24'd13421773;   // shift 27, x < 2^24
    localparam logic [20:0] K_DIV1000_C = 21'd1073742;    // shift 30, x < 2^21

    function automatic t_code old_tab(input logic [5:0] idx);
        t_code v;
        v = '0;
        case (idx)
            6'd1:  v = 32'sd2112;
            6'd2:  v = 32'sd22;
            6'd3:  v = 32'sd11;
            6'd4:  v = 32'sd13;
            6'd5:  v = 32'sd15;
            6'd6:  v = 32'sd12;
            6'd7:  v = 32'sd14;
            6'd8:  v = 32'sd16;
            6'd9:  v = 32'sd2212;
            6'd10: v = 32'sd3122;
            6'd11: v = 32'sd3222;
            6'd12: v = 32'sd3112;
            6'd13: v = 32'sd3322;
            6'd14: v = 32'sd3312;
            6'd15: v = 32'sd3334;
            6'd16: v = 32'sd4122;
            6'd17: v = 32'sd4232;
            6'd18: v = 32'sd4132;
            6'd19: v = 32'sd5122;
            6'd20: v = 32'sd211;
            6'd21: v = 32'sd111;
            6'd22: v = 32'sd321;
            6'd23: v = 32'sd310;
            6'd24: v = 32'sd130;
            6'd25: v = 32'sd411;
            6'd26: v = 32'sd421;
            6'd27: v = 32'sd431;
            6'd28: v = 32'sd521;
            6'd29: v = 32'sd511;
            6'd30: v = 32'sd531;
            6'd31: v = 32'sd1000010020;
            6'd32: v = 32'sd1000010030;
            6'd33: v = 32'sd1000020030;
            6'd34: v = 32'sd1000020040;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_code new_tab(input logic [5:0] idx);
        t_code v;
        v = '0;
        case (idx)
            6'd1:  v = 32'sd2112;
            6'd2:  v = 32'sd22;
            6'd3:  v = 32'sd11;
            6'd4:  v = 32'sd13;
            6'd5:  v = -32'sd2112;
            6'd6:  v = 32'sd12;
            6'd7:  v = 32'sd14;
            6'd8:  v = -32'sd11;
            6'd9:  v = 32'sd2212;
            6'd10: v = 32'sd3122;
            6'd11: v = 32'sd3222;
            6'd12: v = 32'sd3112;
            6'd13: v = 32'sd3322;
            6'd14: v = 32'sd3312;
            6'd15: v = 32'sd3334;
            6'd16: v = -32'sd13;
            6'd17: v = -32'sd12;
            6'd18: v = -32'sd14;
            6'd19: v = -32'sd2212;
            6'd20: v = 32'sd211;
            6'd21: v = 32'sd111;
            6'd22: v = 32'sd321;
            6'd23: v = 32'sd310;
            6'd24: v = 32'sd130;
            6'd25: v = -32'sd3122;
            6'd26: v = -32'sd3222;
            6'd27: v = -32'sd3112;
            6'd28: v = -32'sd3322;
            6'd29: v = -32'sd3312;
            6'd30: v = -32'sd3334;
            6'd31: v = 32'sd1000010020;
            6'd32: v = 32'sd1000010030;
            6'd33: v = 32'sd1000020030;
            6'd34: v = 32'sd1000020040;
            6'd35: v = -32'sd211;
            6'd36: v = -32'sd321;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/particle_code_converter.sv]
// Particle code converter top level: pipeline control and result assembly.
// Converts one particle code per clock between the decimal transport code, the
// bit-packed transport code and standard particle numbers; a code with no
// mapping gives 0. A code passes an input register, three stages that search
// the tables and split ion codes into digits by reciprocal multiplication,
// then the output register that drives o_valid. The pipeline takes a new code
// every cycle and holds as a whole while the output request waits.
`include "particle_code_converter_assert.svh"

module particle_code_converter
    import pcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic signed [31:0] i_code_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_code_out
);

    logic    en;
    logic    r1_v, r2_v, r3_v, r4_v, r_o_v;
    t_cmd    r1_cmd, r2_cmd, r3_cmd, r4_cmd, r_o_cmd;
    t_code   r1_code;
    t_dir    w_dir2, r3_dir, r4_dir;
    t_digits w_dig;
    t_code   n_code, r_o_code;

    // Hold every stage while a finished result is refused.
    assign en      = !(r_o_v && !i_ready);
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (en) begin
            r1_v  <= i_valid;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r_o_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd   <= t_cmd'(i_command);
            r1_code  <= i_code_in;
            r2_cmd   <= r1_cmd;
            r3_cmd   <= r2_cmd;
            r3_dir   <= w_dir2;
            r4_cmd   <= r3_cmd;
            r4_dir   <= r3_dir;
            r_o_cmd  <= r4_cmd;
            r_o_code <= n_code;
        end
    end

    pcc_table u_table (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cmd  (r1_cmd),
        .i_code (r1_code),
        .o_dir  (w_dir2)
    );

    pcc_divide u_divide (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_code (r1_code),
        .o_dig  (w_dig)
    );

    logic [21:0] a_old_full;
    logic [20:0] a_std_full;
    logic [9:0]  a_old, a_std;
    logic        old_ok, std_ok, old_anti;
    t_code       old_val, rev_old, rev_new;

    always_comb begin
        a_old_full = w_dig.q1 - 22'(w_dig.q2) * 22'd1000;
        a_std_full = w_dig.q10 - 21'(w_dig.z) * 21'd1000;
        a_old      = a_old_full[9:0];
        a_std      = a_std_full[9:0];
        old_anti   = (w_dig.low3 == 10'd435);
        old_ok     = (w_dig.low3 == 10'd35 || old_anti) && a_old != 0
                     && w_dig.q2 < 12'd1000;
        old_val    = ION_BASE + 32'd10000 + 32'(w_dig.q1) * 32'd10;
        std_ok     = w_dig.ion_rng && a_std != 0 && w_dig.z != 0
                     && w_dig.z <= 12'(a_std);
        rev_old    = 32'(w_dig.q10) * 32'd1000 - 32'd1000000
                     + (w_dig.neg ? 32'd435 : 32'd35);
        rev_new    = 32'(w_dig.neg) + 32'd74 + (32'(a_std) << 7)
                     + (32'(w_dig.z) << 16) + (32'(w_dig.iso) << 23);
        n_code     = '0;
        unique case (r4_cmd)
            CMD_OLD_TO_STD: begin
                if (r4_dir.hit) begin
                    n_code = r4_dir.val;
                end else if (old_ok) begin
                    n_code = old_anti ? -old_val : old_val;
                end
            end
            CMD_NEW_TO_STD: n_code = r4_dir.val;
            CMD_STD_TO_OLD: begin
                if (r4_dir.hit) begin
                    n_code = r4_dir.val;
                end else if (std_ok && w_dig.iso == 4'd0) begin
                    n_code = rev_old;
                end
            end
            CMD_STD_TO_NEW: begin
                if (r4_dir.hit) begin
                    n_code = r4_dir.val;
                end else if (std_ok) begin
                    n_code = rev_new;
                end
            end
            default: n_code = '0;
        endcase
    end

    assign o_valid    = r_o_v;
    assign o_code_out = r_o_code;

    `PCC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid, "output valid after reset")
    `PCC_ASSERT(a_accept_enters, i_valid && o_ready |=> r1_v, "accepted request lost")
    `PCC_ASSERT(a_last_advances, r4_v && en |=> o_valid, "last stage did not advance")
    `PCC_ASSERT(a_reverse_nonneg, o_valid && (r_o_cmd == CMD_STD_TO_OLD || r_o_cmd == CMD_STD_TO_NEW) |-> !o_code_out[31], "negative transport code")

endmodule

[design/pcc_table.sv]
// Table stage: direct table reads, bit-packed decode and reverse table search.
module pcc_table
    import pcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cmd  i_cmd,
    input  t_code i_code,
    output t_dir  o_dir
);

    t_dir  n_dir;
    t_dir  r_dir;
    t_code neg_code;
    logic  old_pos_hit, old_neg_hit, new_pos_hit, new_neg_hit;
    logic [5:0] old_pos_idx, old_neg_idx, new_pos_idx, new_neg_idx;
    logic [8:0] ion_a;
    logic [6:0] ion_z;
    logic [7:0] ion_s;
    t_code ion_p;
    t_code tab_p;

    always_comb begin
        neg_code    = -i_code;
        old_pos_hit = 1'b0;
        old_neg_hit = 1'b0;
        new_pos_hit = 1'b0;
        new_neg_hit = 1'b0;
        old_pos_idx = '0;
        old_neg_idx = '0;
        new_pos_idx = '0;
        new_neg_idx = '0;
        // Walk downward so the lowest matching index wins.
        for (int i = OLD_COUNT - 1; i >= 0; i--) begin
            if (old_tab(6'(i)) == i_code) begin
                old_pos_hit = 1'b1;
                old_pos_idx = 6'(i);
            end
            if (old_tab(6'(i)) == neg_code) begin
                old_neg_hit = 1'b1;
                old_neg_idx = 6'(i);
            end
        end
        for (int i = NEW_COUNT - 1; i >= 0; i--) begin
            if (new_tab(6'(i)) == i_code) begin
                new_pos_hit = 1'b1;
                new_pos_idx = 6'(i);
            end
            if (new_tab(6'(i)) == neg_code) begin
                new_neg_hit = 1'b1;
                new_neg_idx = 6'(i);
            end
        end
    end

    always_comb begin
        ion_a = i_code[15:7];
        ion_z = i_code[22:16];
        ion_s = i_code[30:23];
        ion_p = ION_BASE + 32'(ion_z) * 32'd10000 + 32'(ion_a) * 32'd10 + 32'(ion_s);
        tab_p = new_tab(i_code[6:1]);
    end

    always_comb begin
        n_dir.hit = 1'b0;
        n_dir.val = '0;
        unique case (i_cmd)
            CMD_OLD_TO_STD: begin
                if (i_code < 0) begin
                    n_dir.hit = 1'b1;
                end else if (i_code <= 34) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = old_tab(i_code[5:0]);
                end else if (i_code >= 401 && i_code <= 434) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = -old_tab(6'(i_code[8:0] - 9'd400));
                end
            end
            CMD_NEW_TO_STD: begin
                n_dir.hit = 1'b1;
                if (i_code[31]) begin
                    n_dir.val = '0;
                end else if (i_code[6:1] < NEW_ION_TYPE) begin
                    n_dir.val = i_code[0] ? -tab_p : tab_p;
                end else if (i_code[6:1] == NEW_ION_TYPE && ion_a != 0 && ion_z != 0
                             && ion_a >= 9'(ion_z) && ion_s <= 8'd9) begin
                    n_dir.val = i_code[0] ? -ion_p : ion_p;
                end
            end
            CMD_STD_TO_OLD: begin
                if (old_pos_hit) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = 32'(old_pos_idx);
                end else if (old_neg_hit) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = 32'd400 + 32'(old_neg_idx);
                end
            end
            CMD_STD_TO_NEW: begin
                // Positron maps to the anti-electron code.
                if (i_code == -32'sd11) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = 32'sd7;
                end else if (new_pos_hit) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = 32'({new_pos_idx, 1'b0});
                end else if (new_neg_hit) begin
                    n_dir.hit = 1'b1;
                    n_dir.val = 32'({new_neg_idx, 1'b1});
                end
            end
            default: n_dir = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dir <= n_dir;
        end
    end

    assign o_dir = r_dir;

endmodule

[design/pcc_divide.sv]
// Three-stage digit split by reciprocal multiplication for ion codes.
module pcc_divide
    import pcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_en,
    input  t_code   i_code,
    output t_digits o_dig
);

    // Stage 2: magnitude, ion offset, code / 1000
    logic [31:0] mag;
    logic [63:0] p1;
    logic [21:0] r2_q1;
    logic [30:0] r2_c;
    logic [23:0] r2_r;
    logic        r2_neg, r2_ion;

    always_comb begin
        mag = i_code[31] ? 32'(-i_code) : 32'(i_code);
        p1  = 64'(i_code[30:0]) * 64'(K_DIV1000_A);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_q1  <= p1[62:41];
            r2_c   <= i_code[30:0];
            r2_r   <= 24'(mag - ION_BASE);
            r2_neg <= i_code[31];
            r2_ion <= (mag > ION_BASE) && (mag <= ION_MAX);
        end
    end

    // Stage 3: second /1000, low three digits, ion offset / 10
    logic [44:0] p2;
    logic [47:0] p3;
    logic [31:0] low_full;
    logic [21:0] r3_q1;
    logic [11:0] r3_q2;
    logic [9:0]  r3_low3;
    logic [20:0] r3_q10;
    logic [23:0] r3_r;
    logic        r3_neg, r3_ion;

    always_comb begin
        p2       = 45'(r2_q1) * 45'(K_DIV1000_B);
        p3       = 48'(r2_r) * 48'(K_DIV10);
        low_full = 32'(r2_c) - 32'(r2_q1) * 32'd1000;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_q1   <= r2_q1;
            r3_q2   <= p2[43:32];
            r3_low3 <= low_full[9:0];
            r3_q10  <= p3[47:27];
            r3_r    <= r2_r;
            r3_neg  <= r2_neg;
            r3_ion  <= r2_ion;
        end
    end

    // Stage 4: Z and isomer level
    logic [41:0] p4;
    logic [23:0] iso_full;
    t_digits     r4_dig;

    always_comb begin
        p4       = 42'(r3_q10) * 42'(K_DIV1000_C);
        iso_full = r3_r - 24'(r3_q10) * 24'd10;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dig.neg     <= r3_neg;
            r4_dig.ion_rng <= r3_ion;
            r4_dig.q1      <= r3_q1;
            r4_dig.q2      <= r3_q2;
            r4_dig.low3    <= r3_low3;
            r4_dig.q10     <= r3_q10;
            r4_dig.z       <= p4[41:30];
            r4_dig.iso     <= iso_full[3:0];
        end
    end

    assign o_dig = r4_dig;

endmodule
